// ===== rtl/lzrd_pkg.sv =====
`default_nettype none
package lzrd_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int START_GAP  = 18;

  localparam logic [RING_AW-1:0] START_POS = RING_AW'(RING_DEPTH - START_GAP);

  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_FINAL = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_ITEM  = 2'd1;
  localparam logic [1:0] PH_MATCH = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COPY,
    S_ERR
  } state_t;

  typedef struct packed {
    logic accept;
    logic copy_emit;
    logic err_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic act_match;
    logic act_err_after;
    logic copy_last;
    logic copy_final;
    logic end_q;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/lzss_ring_decoder.sv =====
// Flag and literal bytes: one request per cycle unless the output stalls, result registered
// at accept. Match: no new request is taken while its n bytes are copied (n = 1..18;
// under 3 only at the length); the first copied byte comes from S_COPY, then one per cycle,
// ring read bound. Trailing errors come from S_ERR. Output stalls hold the copy in place.
// rst (synchronous) clears control state and expected_length; the ring is not cleared,
// reads of unwritten entries are masked by the produced count, so no clearing pass.
`default_nettype none
module lzss_ring_decoder (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_data,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire lzrd_pkg::in_t  item,
  output logic                res_valid,
  input  wire logic           res_ready,
  output lzrd_pkg::out_t      res
);
  import lzrd_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lzrd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lzrd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat)
  );

endmodule
`default_nettype wire

// ===== rtl/lzrd_ram.sv =====
`default_nettype none
module lzrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/lzrd_ctrl.sv =====
`default_nettype none
module lzrd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire lzrd_pkg::dp_stat_t stat,
  output lzrd_pkg::ctrl_cmd_t    cmd
);
  import lzrd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        item_ready = stat.slot_free;
        cmd.accept = item_valid && stat.slot_free;
        if (cmd.accept) begin
          if (stat.act_match) begin
            state_next = S_COPY;
          end else if (stat.act_err_after) begin
            state_next = S_ERR;
          end
        end
      end
      S_COPY: begin
        cmd.copy_emit = stat.slot_free;
        if (stat.slot_free && (stat.copy_final || stat.copy_last)) begin
          state_next = (!stat.copy_final && stat.end_q) ? S_ERR : S_IDLE;
        end
      end
      S_ERR: begin
        cmd.err_emit = stat.slot_free;
        if (stat.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/lzrd_datapath.sv =====
`default_nettype none
module lzrd_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_data,
  input  wire lzrd_pkg::in_t       item,
  input  wire lzrd_pkg::ctrl_cmd_t cmd,
  input  wire logic                res_ready,
  output logic                     res_valid,
  output lzrd_pkg::out_t           res,
  output lzrd_pkg::dp_stat_t       stat
);
  import lzrd_pkg::*;

  logic [31:0]        expected_length;
  logic [31:0]        produced, produced_next;
  logic               done, done_next;
  logic [1:0]         phase, phase_next;
  logic [7:0]         flag_bits, flag_bits_next;
  logic [3:0]         flags_left, flags_left_next;
  logic [7:0]         pending, pending_next;
  logic [RING_AW-1:0] src, src_next;
  logic [4:0]         len_left, len_left_next;
  logic               end_q, end_q_next;
  logic               out_valid, out_valid_next;
  out_t               out_q, out_next;
  logic               bypass_q, fill_q;
  logic [7:0]         fwd_byte;

  logic               start, ignore, over, final_lit, lit, err_now, match;
  logic [31:0]        prod_e;
  logic               done_e;
  logic [1:0]         phase_e, phase_fix;
  logic [7:0]         bits_e;
  logic [3:0]         left_e;
  logic [31:0]        prod_cur;
  logic               copy_final, copy_last;
  logic [7:0]         copy_byte, rdata;
  logic               ram_we;
  logic [RING_AW-1:0] waddr, raddr, roff;
  logic [7:0]         wdata;

  assign start  = item.stream_start;
  assign prod_e = start ? '0 : produced;
  assign done_e = start ? 1'b0 : done;
  assign phase_e = start ? PH_FLAG : phase;
  assign bits_e = start ? '0 : flag_bits;
  assign left_e = start ? '0 : flags_left;

  assign ignore = !start && done;
  assign over   = prod_e >= expected_length;

  always_comb begin
    phase_fix = phase_e;
    if ((phase_e == PH_ITEM && left_e == '0) ||
        (phase_e != PH_FLAG && phase_e != PH_ITEM && phase_e != PH_MATCH)) begin
      phase_fix = PH_FLAG;
    end
  end

  assign final_lit = ({1'b0, prod_e} + 33'd1) >= {1'b0, expected_length};
  assign lit     = !ignore && !over && phase_fix == PH_ITEM && bits_e[0];
  assign match   = !ignore && !over && phase_fix == PH_MATCH;
  assign err_now = !ignore && (over || (item.stream_end &&
                   (phase_fix == PH_FLAG || (phase_fix == PH_ITEM && !bits_e[0]))));

  assign copy_final = ({1'b0, produced} + 33'd1) >= {1'b0, expected_length};
  assign copy_last  = len_left == 5'd1;
  assign copy_byte  = bypass_q ? fwd_byte : (fill_q ? rdata : 8'h00);

  assign stat.slot_free     = !out_valid || res_ready;
  assign stat.act_match     = match;
  assign stat.act_err_after = lit && !final_lit && item.stream_end;
  assign stat.copy_last     = copy_last;
  assign stat.copy_final    = copy_final;
  assign stat.end_q         = end_q;

  // ring port: write at the head, fill count masks entries not yet written
  assign prod_cur = (cmd.accept && start) ? '0 : produced;
  assign ram_we   = (cmd.accept && lit) || cmd.copy_emit;
  assign waddr    = START_POS + prod_cur[RING_AW-1:0];
  assign wdata    = cmd.copy_emit ? copy_byte : item.in_byte;

  always_comb begin
    if (cmd.accept) begin
      raddr = {item.in_byte[7:4], pending};
    end else if (cmd.copy_emit) begin
      raddr = src + RING_AW'(1);
    end else begin
      raddr = src;
    end
  end

  assign roff = raddr - START_POS;

  lzrd_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    produced_next   = produced;
    done_next       = done;
    phase_next      = phase;
    flag_bits_next  = flag_bits;
    flags_left_next = flags_left;
    pending_next    = pending;
    src_next        = src;
    len_left_next   = len_left;
    end_q_next      = end_q;
    out_next        = out_q;
    out_valid_next  = res_ready ? 1'b0 : out_valid;

    if (cmd.accept && !ignore) begin
      produced_next   = prod_e;
      done_next       = done_e;
      phase_next      = phase_e;
      flag_bits_next  = bits_e;
      flags_left_next = left_e;
      if (over) begin
        done_next = 1'b1;
      end else begin
        case (phase_fix)
          PH_ITEM: begin
            flag_bits_next  = {1'b0, bits_e[7:1]};
            flags_left_next = left_e - 4'd1;
            if (bits_e[0]) begin
              produced_next = prod_e + 32'd1;
              done_next     = final_lit;
              phase_next    = (left_e != 4'd1) ? PH_ITEM : PH_FLAG;
              out_next.out_byte = item.in_byte;
              out_next.status   = final_lit ? ST_FINAL : ST_BYTE;
              out_next.run_last = final_lit || !item.stream_end;
              out_valid_next    = 1'b1;
            end else begin
              pending_next = item.in_byte;
              phase_next   = PH_MATCH;
            end
          end
          PH_MATCH: begin
            src_next      = {item.in_byte[7:4], pending};
            len_left_next = {1'b0, item.in_byte[3:0]} + 5'd3;
            end_q_next    = item.stream_end;
            phase_next    = (left_e != '0) ? PH_ITEM : PH_FLAG;
          end
          default: begin
            flag_bits_next  = item.in_byte;
            flags_left_next = 4'd8;
            phase_next      = PH_ITEM;
          end
        endcase
      end
      if (err_now) begin
        done_next         = 1'b1;
        out_next.out_byte = 8'h00;
        out_next.status   = ST_ERROR;
        out_next.run_last = 1'b1;
        out_valid_next    = 1'b1;
      end
    end

    if (cmd.copy_emit) begin
      produced_next     = produced + 32'd1;
      done_next         = done || copy_final;
      src_next          = src + RING_AW'(1);
      len_left_next     = len_left - 5'd1;
      out_next.out_byte = copy_byte;
      out_next.status   = copy_final ? ST_FINAL : ST_BYTE;
      out_next.run_last = copy_final || (copy_last && !end_q);
      out_valid_next    = 1'b1;
    end

    if (cmd.err_emit) begin
      done_next         = 1'b1;
      out_next.out_byte = 8'h00;
      out_next.status   = ST_ERROR;
      out_next.run_last = 1'b1;
      out_valid_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= '0;
      produced        <= '0;
      done            <= 1'b0;
      phase           <= PH_FLAG;
      flag_bits       <= '0;
      flags_left      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        expected_length <= cfg_data;
      end
      produced   <= produced_next;
      done       <= done_next;
      phase      <= phase_next;
      flag_bits  <= flag_bits_next;
      flags_left <= flags_left_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pending  <= pending_next;
    src      <= src_next;
    len_left <= len_left_next;
    end_q    <= end_q_next;
    out_q    <= out_next;
    fwd_byte <= wdata;
    bypass_q <= ram_we && raddr == waddr;
    fill_q   <= {{(32-RING_AW){1'b0}}, roff} < prod_cur;
  end

  assign res_valid = out_valid;
  assign res       = out_q;

endmodule
`default_nettype wire

// ===== rtl/lzrd_checker.sv =====
`default_nettype none
module lzrd_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           item_valid,
  input wire logic           item_ready,
  input wire logic           res_valid,
  input wire logic           res_ready,
  input wire lzrd_pkg::out_t res
);
  import lzrd_pkg::*;

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_ERROR |-> res.run_last && res.out_byte == 8'h00)
    else $error("error result not last or not zero");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_FINAL |-> res.run_last)
    else $error("final byte not last of its request");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.run_last |-> !item_ready)
    else $error("new request taken mid-run");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid)
    else $error("request dropped before accept");

endmodule

bind lzss_ring_decoder lzrd_checker u_chk (.*);
`default_nettype wire
